// ===== rtl/spr_pkg.sv =====
// Shared types and constants for the servo pulse ramp generator.
package spr_pkg;

    localparam int SEG_W   = 7;   // segment count field
    localparam int DLY_W   = 13;  // delay field
    localparam int SPEED_W = 10;  // speed rating register
    localparam int ADDR_W  = 4;   // APB byte address
    localparam int DATA_W  = 32;  // APB data
    localparam int DIV_W   = 7;   // divisor width, holds up to 64

    // |step| * 150 / 1400 = |step| * 3 / 28 = floor(floor(3 * |step| / 4) / 7)
    localparam int SCALE_SHIFT  = 2;
    // floor(z / 7) = (z * RECIP7) >> RECIP7_SHIFT, exact for z below 104857
    localparam int RECIP7       = 74899;
    localparam int RECIP7_W     = 17;
    localparam int RECIP7_SHIFT = 19;

    // m * speed / 60 = floor(floor(p / 4) / 15)
    localparam int RATE_SHIFT    = 2;
    // floor(w / 15) = (w * RECIP15) >> RECIP15_SHIFT, exact for w below 2581110
    localparam int RECIP15       = 2236963;
    localparam int RECIP15_W     = 22;
    localparam int RECIP15_SHIFT = 25;

    typedef enum logic [1:0] {
        REG_MIN   = 2'd0,
        REG_MAX   = 2'd1,
        REG_SPEED = 2'd2
    } reg_idx_t;

    typedef enum logic [7:0] {
        ST_IDLE   = 8'b0000_0001,
        ST_LOAD   = 8'b0000_0010,
        ST_DIRECT = 8'b0000_0100,
        ST_DIVS   = 8'b0000_1000,
        ST_SCALE  = 8'b0001_0000,
        ST_MUL    = 8'b0010_0000,
        ST_RATE   = 8'b0100_0000,
        ST_STEP   = 8'b1000_0000
    } state_t;

    typedef struct packed {
        logic     load;
        logic     div_start;
        logic     latch_mag;
        logic     latch_m;
        logic     load_prod;
        logic     latch_dly;
        logic     emit_direct;
        logic     emit_step;
    } dp_cmd_t;

    typedef struct packed {
        logic kind;
        logic seg_zero;
        logic div_done;
        logic out_free;
        logic last_step;
    } dp_sts_t;

endpackage

// ===== rtl/spr_div.sv =====
// Restoring divider, one quotient bit per cycle.
module spr_div #(
    parameter int DW = 25
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic [DW-1:0]              dividend,
    input  logic [spr_pkg::DIV_W-1:0]  divisor,
    output logic [DW-1:0]              quotient,
    output logic                       done
);
    import spr_pkg::*;

    localparam int CW = $clog2(DW + 1);

    logic [DW-1:0]    quo_reg;
    logic [DIV_W-1:0] rem_reg;
    logic [DIV_W-1:0] div_reg;
    logic [CW-1:0]    cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [DIV_W-1:0] trial;
    logic             ge;

    // remainder stays below the divisor (at most 64), so its top bit is free
    assign trial = {rem_reg[DIV_W-2:0], quo_reg[DW-1]};
    assign ge    = (trial >= div_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(DW);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - CW'(1);
                if (cnt_reg == CW'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= dividend;
            rem_reg <= '0;
            div_reg <= divisor;
        end else if (busy_reg) begin
            rem_reg <= ge ? (trial - div_reg) : trial;
            quo_reg <= {quo_reg[DW-2:0], ge};
        end
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

endmodule

// ===== rtl/spr_dp.sv =====
// Datapath: command registers, step/delay arithmetic, clamp and result register.
module spr_dp #(
    parameter int PULSE_BITS   = 12,
    parameter int MAX_SEGMENTS = 64
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  spr_pkg::dp_cmd_t              cmd,
    output spr_pkg::dp_sts_t              sts,
    input  logic                          s_kind,
    input  logic [PULSE_BITS-1:0]         s_target_us,
    input  logic [spr_pkg::SEG_W-1:0]     s_segments,
    input  logic [PULSE_BITS-1:0]         min_pulse,
    input  logic [PULSE_BITS-1:0]         max_pulse,
    input  logic [spr_pkg::SPEED_W-1:0]   speed,
    input  logic                          m_ready,
    output logic                          m_valid,
    output logic [PULSE_BITS-1:0]         m_pulse_us,
    output logic [spr_pkg::DLY_W-1:0]     m_delay_ms,
    output logic                          m_last
);
    import spr_pkg::*;

    localparam int PB = PULSE_BITS;
    localparam int PW = PB + 3;              // signed step arithmetic
    localparam int MW = PB - 2;              // scaled step magnitude
    localparam int ZW = PB;                  // 3 * |step| / 4
    localparam int QW = MW + SPEED_W;        // m * speed
    localparam int WW = QW - RATE_SHIFT;     // m * speed / 4
    localparam int RW = (WW + RECIP15_W > RECIP15_SHIFT + DLY_W) ?
                        (WW + RECIP15_W) : (RECIP15_SHIFT + DLY_W);

    logic                 kind_reg;
    logic [PB-1:0]        tgt_reg;
    logic [SEG_W-1:0]     seg_reg;
    logic [SEG_W-1:0]     cnt_reg;
    logic [PB-1:0]        cur_reg;
    logic                 neg_reg;
    logic                 zero_reg;
    logic [PB:0]          mag_reg;
    logic [MW-1:0]        m_reg;
    logic [QW-1:0]        prod_reg;
    logic [DLY_W-1:0]     dly_reg;
    logic                 m_valid_reg;
    logic [PB-1:0]        pulse_reg;
    logic [DLY_W-1:0]     delay_reg;
    logic                 last_reg;

    logic [SEG_W-1:0]     seg_sat;
    logic [PB-1:0]        abs_diff;
    logic                 cur_below;
    logic                 cur_equal;
    logic [PB-1:0]        quo;
    logic                 div_done;
    logic [PB:0]          mag_next;
    logic [PB+1:0]        mag3;
    logic [ZW-1:0]        scale_z;
    logic [ZW+RECIP7_W-1:0] scale_prod;
    logic [MW-1:0]        m_next;
    logic [QW-1:0]        prod_next;
    logic [WW-1:0]        rate_w;
    logic [RW-1:0]        rate_prod;
    logic [DLY_W-1:0]     dly_next;
    logic signed [PW-1:0] cur_s;
    logic signed [PW-1:0] tgt_s;
    logic signed [PW-1:0] mag_s;
    logic signed [PW-1:0] step_s;
    logic signed [PW-1:0] pos_s;
    logic                 snap;
    logic [PB-1:0]        step_pulse;
    logic [PB-1:0]        direct_pulse;
    logic                 out_free;

    // max test wins when the window is inverted
    function automatic logic [PB-1:0] clamp_pulse(
        input logic signed [PW-1:0] v,
        input logic [PB-1:0]        lo,
        input logic [PB-1:0]        hi
    );
        logic signed [PW-1:0] lo_s;
        logic signed [PW-1:0] hi_s;
        lo_s = $signed({3'b000, lo});
        hi_s = $signed({3'b000, hi});
        if (v >= hi_s)
            return hi;
        else if (v <= lo_s)
            return lo;
        else
            return v[PB-1:0];
    endfunction

    assign seg_sat = (s_segments > SEG_W'(MAX_SEGMENTS)) ? SEG_W'(MAX_SEGMENTS) : s_segments;

    assign cur_below = (cur_reg < tgt_reg);
    assign cur_equal = (cur_reg == tgt_reg);
    assign abs_diff  = cur_below ? (tgt_reg - cur_reg) : (cur_reg - tgt_reg);

    // |diff| / seg, the only division by a variable
    spr_div #(
        .DW (PB)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (abs_diff),
        .divisor  (seg_reg),
        .quotient (quo),
        .done     (div_done)
    );

    // step = trunc(diff / seg) + sign(diff), kept as magnitude and sign
    assign mag_next  = cur_equal ? '0 : ({1'b0, quo} + (PB+1)'(1));

    // m = floor(|step| * 3 / 28)
    assign mag3       = {1'b0, mag_reg} + {mag_reg, 1'b0};
    assign scale_z    = mag3[PB+1:SCALE_SHIFT];
    assign scale_prod = (ZW+RECIP7_W)'(scale_z) * (ZW+RECIP7_W)'(RECIP7);
    assign m_next     = scale_prod[RECIP7_SHIFT +: MW];

    assign prod_next = QW'(m_reg) * QW'(speed);

    // delay = floor(m * speed / 60) + 1
    assign rate_w    = prod_reg[QW-1:RATE_SHIFT];
    assign rate_prod = RW'(rate_w) * RW'(RECIP15);
    assign dly_next  = rate_prod[RECIP15_SHIFT +: DLY_W] + DLY_W'(1);

    // one ramp step
    assign cur_s  = $signed({3'b000, cur_reg});
    assign tgt_s  = $signed({3'b000, tgt_reg});
    assign mag_s  = $signed({2'b00, mag_reg});
    assign step_s = zero_reg ? '0 : (neg_reg ? -mag_s : mag_s);
    assign pos_s  = cur_s - step_s;
    assign snap   = !zero_reg && ((!neg_reg && (pos_s < tgt_s)) || (neg_reg && (pos_s > tgt_s)));

    assign step_pulse   = clamp_pulse(snap ? tgt_s : pos_s, min_pulse, max_pulse);
    assign direct_pulse = clamp_pulse(tgt_s, min_pulse, max_pulse);

    assign out_free = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cmd.emit_direct) begin
                cur_reg <= direct_pulse;
            end else if (cmd.emit_step) begin
                cur_reg <= step_pulse;
            end
            if (cmd.emit_direct || cmd.emit_step) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            kind_reg <= s_kind;
            tgt_reg  <= s_target_us;
            seg_reg  <= seg_sat;
            cnt_reg  <= seg_sat;
        end else if (cmd.emit_step) begin
            cnt_reg <= cnt_reg - SEG_W'(1);
        end

        if (cmd.latch_mag) begin
            mag_reg  <= mag_next;
            neg_reg  <= cur_below;
            zero_reg <= cur_equal;
        end else if (cmd.emit_step) begin
            zero_reg <= zero_reg | snap;
        end

        if (cmd.latch_m) begin
            m_reg <= m_next;
        end
        if (cmd.load_prod) begin
            prod_reg <= prod_next;
        end
        if (cmd.latch_dly) begin
            dly_reg <= dly_next;
        end

        if (cmd.emit_direct) begin
            pulse_reg <= direct_pulse;
            delay_reg <= '0;
            last_reg  <= 1'b1;
        end else if (cmd.emit_step) begin
            pulse_reg <= step_pulse;
            delay_reg <= (zero_reg || snap) ? DLY_W'(1) : dly_reg;
            last_reg  <= (cnt_reg == SEG_W'(1));
        end
    end

    assign sts.kind      = kind_reg;
    assign sts.seg_zero  = (seg_reg == '0);
    assign sts.div_done  = div_done;
    assign sts.out_free  = out_free;
    assign sts.last_step = (cnt_reg == SEG_W'(1));

    assign m_valid    = m_valid_reg;
    assign m_pulse_us = pulse_reg;
    assign m_delay_ms = delay_reg;
    assign m_last     = last_reg;

endmodule

// ===== rtl/spr_ctrl.sv =====
// Controller: sequences command load, direct results, division, delay stages and ramp steps.
module spr_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  spr_pkg::dp_sts_t  sts,
    output spr_pkg::dp_cmd_t  cmd
);
    import spr_pkg::*;

    state_t state_reg;
    state_t state_next;

    assign s_ready = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD: begin
                if (!sts.kind) begin
                    state_next = ST_DIRECT;
                end else if (sts.seg_zero) begin
                    state_next = ST_IDLE;
                end else begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_DIVS;
                end
            end
            ST_DIRECT: begin
                if (sts.out_free) begin
                    cmd.emit_direct = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            ST_DIVS: begin
                if (sts.div_done) begin
                    cmd.latch_mag = 1'b1;
                    state_next    = ST_SCALE;
                end
            end
            ST_SCALE: begin
                cmd.latch_m = 1'b1;
                state_next  = ST_MUL;
            end
            ST_MUL: begin
                cmd.load_prod = 1'b1;
                state_next    = ST_RATE;
            end
            ST_RATE: begin
                cmd.latch_dly = 1'b1;
                state_next    = ST_STEP;
            end
            ST_STEP: begin
                if (sts.out_free) begin
                    cmd.emit_step = 1'b1;
                    if (sts.last_step) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== rtl/servo_pulse_ramp_generator.sv =====
// Servo pulse ramp generator top level: APB registers, controller and datapath.
//
// Each input transfer is one move command. A direct move (kind 0) clamps the
// target into the [min, max] window, stores it as the current pulse and
// produces one result with delay 0. A segmented move (kind 1) produces one
// result per segment (segments above MAX_SEGMENTS saturate, zero segments
// produce nothing); each result steps the current pulse toward the target by
// trunc(diff/seg)+sign(diff), snaps to the target once it would overshoot,
// and carries a delay of floor(floor(|step|*3/28)*speed/60)+1 ms, or 1 ms
// once snapped. Before the first step the block divides the pulse difference
// by the segment count on a restoring divider, one quotient bit per cycle
// over PULSE_BITS bits, then works out the delay in the SCALE, MUL and RATE
// states: the divides by 28 and by 60 are reciprocal multiplies with the
// speed product between them. The results then enter the output register
// one per cycle while the result side keeps taking transfers. A new command
// is taken only after the last result of the previous one has entered the
// output register. Configuration writes belong in idle periods only; a write
// to the min, max or speed register is seen by the next command. The current
// pulse resets to zero.
module servo_pulse_ramp_generator #(
    parameter int PULSE_BITS   = 12,
    parameter int MAX_SEGMENTS = 64
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // APB configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [spr_pkg::ADDR_W-1:0]    paddr,
    input  logic [spr_pkg::DATA_W-1:0]    pwdata,
    output logic [spr_pkg::DATA_W-1:0]    prdata,
    output logic                          pready,
    // command input
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_kind,
    input  logic [PULSE_BITS-1:0]         s_target_us,
    input  logic [spr_pkg::SEG_W-1:0]     s_segments,
    // result output
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [PULSE_BITS-1:0]         m_pulse_us,
    output logic [spr_pkg::DLY_W-1:0]     m_delay_ms,
    output logic                          m_last
);
    import spr_pkg::*;

    localparam int PB = PULSE_BITS;

    logic [PB-1:0]      min_reg;
    logic [PB-1:0]      max_reg;
    logic [SPEED_W-1:0] speed_reg;
    logic               wr_en;
    reg_idx_t           reg_idx;
    dp_cmd_t            cmd;
    dp_sts_t            sts;

    // register index from the word address; byte lanes are ignored
    assign reg_idx = reg_idx_t'(paddr[ADDR_W-1:2]);
    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_reg   <= PB'(1000);
            max_reg   <= PB'(2000);
            speed_reg <= SPEED_W'(200);
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_MIN:   min_reg   <= pwdata[PB-1:0];
                REG_MAX:   max_reg   <= pwdata[PB-1:0];
                REG_SPEED: speed_reg <= pwdata[SPEED_W-1:0];
                default: ;  // unmapped address: write dropped
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_MIN:   prdata = DATA_W'(min_reg);
            REG_MAX:   prdata = DATA_W'(max_reg);
            REG_SPEED: prdata = DATA_W'(speed_reg);
            default:   prdata = '0;
        endcase
    end

    // sequencing
    spr_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // arithmetic, current pulse and result register
    spr_dp #(
        .PULSE_BITS   (PULSE_BITS),
        .MAX_SEGMENTS (MAX_SEGMENTS)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .sts         (sts),
        .s_kind      (s_kind),
        .s_target_us (s_target_us),
        .s_segments  (s_segments),
        .min_pulse   (min_reg),
        .max_pulse   (max_reg),
        .speed       (speed_reg),
        .m_ready     (m_ready),
        .m_valid     (m_valid),
        .m_pulse_us  (m_pulse_us),
        .m_delay_ms  (m_delay_ms),
        .m_last      (m_last)
    );

endmodule

// ===== verif/servo_pulse_ramp_generator_tb.sv =====
// Self-checking testbench for the servo pulse ramp generator.
`timescale 1ns / 1ps

module servo_pulse_ramp_generator_tb;
    import spr_pkg::*;

    localparam int PULSE_BITS   = 12;
    localparam int MAX_SEGMENTS = 64;
    localparam int PULSE_TOP    = (1 << PULSE_BITS) - 1;
    localparam int SEG_TOP      = (1 << SEG_W) - 1;
    localparam int SPEED_TOP    = (1 << SPEED_W) - 1;

    // servo travel scaling: |stride| * 150 / 1400, then * speed / 60
    localparam int DEG_TRAVEL     = 150;
    localparam int PULSE_SPAN     = 1400;
    localparam int DEG_PER_RATING = 60;

    localparam int RESET_MIN   = 1000;
    localparam int RESET_MAX   = 2000;
    localparam int RESET_SPEED = 200;

    localparam int CLK_HALF        = 5;
    localparam int RESET_CYCLES    = 11;
    localparam int MAX_IDLE        = 6;
    // time for a trailing command with no results to retire
    localparam int DRAIN_CYCLES    = 150;
    localparam int RANDOM_PHASES   = 6;
    localparam int ITEMS_PER_PHASE = 75;
    localparam int MAX_PRINTED     = 60;
    localparam int LIMIT_CYCLES    = 2_000_000;

    // index 3 decodes to no register; writes there must be dropped
    localparam logic [1:0] UNMAPPED_REG = 2'd3;

    typedef enum logic {
        MOVE_DIRECT = 1'b0,
        MOVE_RAMP   = 1'b1
    } move_kind_t;

    typedef struct packed {
        logic [PULSE_BITS-1:0] pulse_us;
        logic [DLY_W-1:0]      delay_ms;
        logic                  last;
    } step_result_t;

    // Mirrors the register file and current pulse, predicts every step
    // of a move and checks the result transfers in order.
    class ramp_scoreboard;
        int min_pulse;
        int max_pulse;
        int speed_rating;
        int current_pulse;
        int mismatches;
        step_result_t expected_steps[$];

        function new();
            min_pulse     = RESET_MIN;
            max_pulse     = RESET_MAX;
            speed_rating  = RESET_SPEED;
            current_pulse = 0;
            mismatches    = 0;
        endfunction

        function void set_register(logic [1:0] idx, logic [DATA_W-1:0] value);
            case (idx)
                REG_MIN: begin
                    min_pulse = int'(value[PULSE_BITS-1:0]);
                end
                REG_MAX: begin
                    max_pulse = int'(value[PULSE_BITS-1:0]);
                end
                REG_SPEED: begin
                    speed_rating = int'(value[SPEED_W-1:0]);
                end
                default: begin
                end
            endcase
        endfunction

        // max test first: inverted windows give max at or above max, else min
        function int clamp_pulse(int v);
            if (v >= max_pulse) return max_pulse;
            if (v <= min_pulse) return min_pulse;
            return v & PULSE_TOP;
        endfunction

        function logic [DLY_W-1:0] travel_delay(int stride);
            int mag;
            int m;
            mag = (stride < 0) ? -stride : stride;
            m = (mag * DEG_TRAVEL) / PULSE_SPAN;
            return DLY_W'((m * speed_rating) / DEG_PER_RATING + 1);
        endfunction

        function void note_command(move_kind_t kind, int target, int seg);
            int diff;
            int stride;
            int pos;
            step_result_t r;
            if (kind == MOVE_DIRECT) begin
                current_pulse = clamp_pulse(target);
                r.pulse_us = PULSE_BITS'(current_pulse);
                r.delay_ms = '0;
                r.last     = 1'b1;
                expected_steps.push_back(r);
                return;
            end
            if (seg == 0) return;
            if (seg > MAX_SEGMENTS) seg = MAX_SEGMENTS;
            diff = current_pulse - target;
            if (diff > 0) stride = diff / seg + 1;
            else if (diff < 0) stride = -((-diff) / seg) - 1;
            else stride = 0;
            for (int i = 0; i < seg; i++) begin
                pos = current_pulse - stride;
                // overshoot snaps onto the target and freezes the stride
                if ((stride > 0 && pos < target) || (stride < 0 && pos > target)) begin
                    pos    = target;
                    stride = 0;
                end
                current_pulse = clamp_pulse(pos);
                r.pulse_us = PULSE_BITS'(current_pulse);
                r.delay_ms = travel_delay(stride);
                r.last     = (i == seg - 1);
                expected_steps.push_back(r);
            end
        endfunction

        function int pending();
            return expected_steps.size();
        endfunction

        task report_mismatch(string what);
            mismatches++;
            // keep the log bounded when the block is badly off
            if (mismatches <= MAX_PRINTED) $display("[%0t] %s", $time, what);
        endtask

        task check_result(logic [PULSE_BITS-1:0] pulse, logic [DLY_W-1:0] delay,
                          logic last);
            step_result_t want;
            if (expected_steps.size() == 0) begin
                report_mismatch($sformatf("unexpected result transfer pulse=%0d delay=%0d last=%0b",
                                          pulse, delay, last));
                return;
            end
            want = expected_steps.pop_front();
            if (pulse !== want.pulse_us)
                report_mismatch($sformatf("pulse_us got %0d want %0d", pulse, want.pulse_us));
            if (delay !== want.delay_ms)
                report_mismatch($sformatf("delay_ms got %0d want %0d", delay, want.delay_ms));
            if (last !== want.last)
                report_mismatch($sformatf("last got %0b want %0b", last, want.last));
        endtask
    endclass

    logic                  aclk;
    logic                  aresetn     = 1'b0;
    logic                  psel        = 1'b0;
    logic                  penable     = 1'b0;
    logic                  pwrite      = 1'b0;
    logic [ADDR_W-1:0]     paddr       = '0;
    logic [DATA_W-1:0]     pwdata      = '0;
    logic [DATA_W-1:0]     prdata;
    logic                  pready;
    logic                  s_valid     = 1'b0;
    logic                  s_ready;
    logic                  s_kind      = 1'b0;
    logic [PULSE_BITS-1:0] s_target_us = '0;
    logic [SEG_W-1:0]      s_segments  = '0;
    logic                  m_valid;
    logic                  m_ready     = 1'b0;
    logic [PULSE_BITS-1:0] m_pulse_us;
    logic [DLY_W-1:0]      m_delay_ms;
    logic                  m_last;

    // when set, that side runs back to back with no idle cycles
    bit cmd_burst    = 1'b0;
    bit result_burst = 1'b0;

    ramp_scoreboard sb = new();

    servo_pulse_ramp_generator #(
        .PULSE_BITS   (PULSE_BITS),
        .MAX_SEGMENTS (MAX_SEGMENTS)
    ) u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_kind      (s_kind),
        .s_target_us (s_target_us),
        .s_segments  (s_segments),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_pulse_us  (m_pulse_us),
        .m_delay_ms  (m_delay_ms),
        .m_last      (m_last)
    );

    initial begin
        aclk = 1'b0;
        forever #CLK_HALF aclk = ~aclk;
    end

    // Watchdog: a hang or a lost result ends up here.
    initial begin
        #(LIMIT_CYCLES * 2 * CLK_HALF);
        $display("Mismatches found");
        $finish;
    end

    // Transfer monitor. Inputs move on the falling edge, so everything read
    // here is the value that the rising edge actually samples.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready)
                sb.note_command(move_kind_t'(s_kind), int'(s_target_us), int'(s_segments));
            if (m_valid && m_ready)
                sb.check_result(m_pulse_us, m_delay_ms, m_last);
        end
    end

    // Result side: a random stall before each transfer, ready then held
    // until the transfer happens. Runs of zero stall come from result_burst.
    initial begin : result_sink
        int stall;
        while (!aresetn) @(negedge aclk);
        forever begin
            stall = result_burst ? 0 : $urandom_range(0, MAX_IDLE);
            if ($urandom_range(0, 15) == 0) result_burst = !result_burst;
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
            @(negedge aclk);
        end
    end

    // Issue one move command. Entered and left on a falling edge; valid
    // stays high into the next call when no gap is drawn.
    task automatic send_command(move_kind_t kind, int target, int seg);
        int gap;
        gap = cmd_burst ? 0 : $urandom_range(0, MAX_IDLE);
        if ($urandom_range(0, 15) == 0) cmd_burst = !cmd_burst;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid     <= 1'b1;
        s_kind      <= kind;
        s_target_us <= PULSE_BITS'(target);
        s_segments  <= SEG_W'(seg);
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    // APB write: setup cycle, then access cycle until pready.
    task automatic write_register(logic [1:0] idx, logic [DATA_W-1:0] value);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.set_register(idx, value);
    endtask

    // Stop issuing, wait for every predicted result, then give a trailing
    // zero-segment command time to retire before touching registers.
    task automatic finish_phase();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.pending() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        @(negedge aclk);
    endtask

    initial begin : stimulus
        int lo;
        int hi;
        int spd;
        int target;
        int seg;
        int noise;

        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed, reset window [1000, 2000], speed 200.
        send_command(MOVE_DIRECT, 0, 1);            // clamps up to min
        send_command(MOVE_DIRECT, PULSE_TOP, 0);    // clamps down to max
        send_command(MOVE_DIRECT, 1500, SEG_TOP);   // segments ignored
        send_command(MOVE_RAMP, 1500, 5);           // zero difference
        send_command(MOVE_RAMP, 1000, 0);           // zero segments, no result
        send_command(MOVE_RAMP, 1510, 3);           // overshoot snaps to target
        send_command(MOVE_RAMP, PULSE_TOP, MAX_SEGMENTS);
        send_command(MOVE_RAMP, 0, SEG_TOP);        // saturates to max segments
        send_command(MOVE_RAMP, 1234, 1);
        send_command(MOVE_RAMP, 1999, MAX_SEGMENTS + 1);
        send_command(MOVE_DIRECT, 2000, 1);
        send_command(MOVE_DIRECT, 1000, 1);
        finish_phase();

        // Inverted window: max test wins, everything lands on zero.
        write_register(REG_MIN, DATA_W'(PULSE_TOP));
        write_register(REG_MAX, '0);
        write_register(REG_SPEED, DATA_W'(SPEED_TOP));
        write_register(UNMAPPED_REG, 32'hFFFF_FFFF);
        send_command(MOVE_DIRECT, 2048, 1);
        send_command(MOVE_RAMP, PULSE_TOP, 7);
        send_command(MOVE_RAMP, 0, 2);
        finish_phase();

        // Full window, speed zero: every ramp delay collapses to 1.
        write_register(REG_MIN, '0);
        write_register(REG_MAX, DATA_W'(PULSE_TOP));
        write_register(REG_SPEED, '0);
        send_command(MOVE_DIRECT, 0, 1);
        send_command(MOVE_RAMP, PULSE_TOP, MAX_SEGMENTS);
        send_command(MOVE_RAMP, 0, 1);
        finish_phase();

        // Full swing in one step at top speed: the step snaps, so the delay is 1.
        write_register(REG_SPEED, DATA_W'(SPEED_TOP));
        send_command(MOVE_RAMP, PULSE_TOP, 1);
        send_command(MOVE_RAMP, 0, 1);
        finish_phase();

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            case ($urandom_range(0, 4))
                0: begin
                    lo = 0;
                    hi = PULSE_TOP;
                end
                1: begin
                    lo = PULSE_TOP;
                    hi = 0;
                end
                2: begin
                    lo = $urandom_range(0, PULSE_TOP);
                    hi = lo;
                end
                default: begin
                    lo = $urandom_range(0, PULSE_TOP);
                    hi = $urandom_range(0, PULSE_TOP);
                    if (lo > hi) begin
                        noise = lo;
                        lo    = hi;
                        hi    = noise;
                    end
                end
            endcase
            case ($urandom_range(0, 3))
                0: spd = 0;
                1: spd = SPEED_TOP;
                default: spd = $urandom_range(0, SPEED_TOP);
            endcase
            // junk above the register width must be dropped
            noise = $urandom_range(0, 'hFFFF);
            write_register(REG_MIN, {noise[15:0], 16'(lo)});
            write_register(REG_MAX, {noise[7:0], noise[15:8], 16'(hi)});
            write_register(REG_SPEED, {noise[15:0], 16'(spd)});
            if ($urandom_range(0, 1) == 0) write_register(UNMAPPED_REG, $urandom);

            for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
                case ($urandom_range(0, 9))
                    0: target = 0;
                    1: target = PULSE_TOP;
                    2: target = sb.min_pulse + $urandom_range(0, 2) - 1;
                    3: target = sb.max_pulse + $urandom_range(0, 2) - 1;
                    default: target = $urandom_range(0, PULSE_TOP);
                endcase
                if (target < 0) target = 0;
                if (target > PULSE_TOP) target = PULSE_TOP;

                case ($urandom_range(0, 19))
                    0: seg = 0;
                    1, 2: seg = $urandom_range(MAX_SEGMENTS + 1, SEG_TOP);
                    3, 4, 5, 6: seg = $urandom_range(1, 4);
                    default: seg = $urandom_range(1, MAX_SEGMENTS);
                endcase

                case ($urandom_range(0, 9))
                    0, 1: send_command(MOVE_DIRECT, target, $urandom_range(0, SEG_TOP));
                    2: begin
                        // land, then ramp to it: no difference unless clamped
                        send_command(MOVE_DIRECT, target, seg);
                        send_command(MOVE_RAMP, target, seg);
                        i++;
                    end
                    default: send_command(MOVE_RAMP, target, seg);
                endcase
            end
            finish_phase();
        end

        if (sb.mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/spr_pkg.sv
rtl/spr_div.sv
rtl/spr_dp.sv
rtl/spr_ctrl.sv
rtl/servo_pulse_ramp_generator.sv
verif/servo_pulse_ramp_generator_tb.sv
